// ===== design/lfpr_pkg.sv =====
// lfpr_pkg: shared types and constants for the length framed packet receiver
// used by lfpr_ctrl, lfpr_dp and length_framed_packet_receiver
package lfpr_pkg;

  localparam int unsigned LEN_POS   = 8;   // frame byte that carries the length
  localparam int unsigned HDR_EXTRA = 9;   // frame size is length plus this
  localparam int unsigned SUM_START = 6;   // first byte covered by the checksum
  localparam int unsigned GAP_RESET = 280; // gap limit after reset, in ms

  // result status codes
  typedef enum logic [1:0] {
    STAT_BYTE    = 2'd0,
    STAT_SUM_ERR = 2'd1,
    STAT_LEN_ERR = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_CHECK,
    ST_REPLAY,
    ST_SUM_ERR,
    ST_LEN_ERR
  } state_e;

  // store read address select
  typedef enum logic [1:0] {
    RD_SUM_START,
    RD_NEXT,
    RD_TAIL,
    RD_ZERO
  } rd_sel_e;

  // controller to datapath
  typedef struct packed {
    logic    in_take;  // input item accepted this cycle
    logic    rd_en;    // read the store, index follows the read address
    rd_sel_e rd_sel;
    logic    sum_rd;   // the read issued now is a checksum term
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic len_err;   // incoming item carries an oversized length
    logic complete;  // incoming item completes a frame
    logic sum_end;   // index sits on the last checksum byte
    logic is_last;   // index sits on the last frame byte
    logic sum_ok;    // checksum matches the trailing byte
  } sts_t;

endpackage

// ===== design/lfpr_dp.sv =====
// lfpr_dp: frame store, byte counters, checksum accumulator and gap limit
// register; driven by lfpr_ctrl commands, uses lfpr_pkg
module lfpr_dp #(
  parameter int unsigned FRAME_CAP = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lfpr_pkg::cmd_t       cmd_i,
  output lfpr_pkg::sts_t       sts_o,
  input  logic                 cfg_take_i,
  input  logic [15:0]          cfg_data_i,
  input  logic [7:0]           rx_byte_i,
  input  logic [15:0]          gap_ms_i,
  input  logic                 emit_byte_i,
  output logic [7:0]           frame_byte_o
);
  import lfpr_pkg::*;

  localparam int unsigned AW = $clog2(FRAME_CAP);
  localparam int unsigned CW = $clog2(FRAME_CAP + 1);

  logic [7:0]    mem [FRAME_CAP];
  logic [7:0]    rd_data_q;
  logic [15:0]   gap_limit_q;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] total_q, total_d;
  logic [CW-1:0] len_q;
  logic [AW-1:0] idx_q;
  logic [7:0]    sum_q;
  logic          sum_vld_q;

  logic          restart;
  logic [CW-1:0] pos, tot_base, tot_new, cnt_new;
  logic          at_len;
  logic [8:0]    total9;
  logic          len_err, complete;
  logic [AW-1:0] rd_addr;

  // new item against the current frame
  always_comb begin
    restart  = gap_ms_i > gap_limit_q;
    pos      = restart ? '0 : count_q;
    tot_base = restart ? '0 : total_q;
    at_len   = pos == CW'(LEN_POS);
    total9   = {1'b0, rx_byte_i} + 9'(HDR_EXTRA);
    len_err  = at_len && (total9 > 9'(FRAME_CAP));
    tot_new  = at_len ? total9[CW-1:0] : tot_base;
    cnt_new  = pos + CW'(1);
    complete = !len_err && (tot_new != '0) && (cnt_new >= tot_new);
    if (complete || len_err) begin
      count_d = '0;
      total_d = '0;
    end else begin
      count_d = cnt_new;
      total_d = tot_new;
    end
  end

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_SUM_START: rd_addr = AW'(SUM_START);
      RD_NEXT:      rd_addr = idx_q + AW'(1);
      RD_TAIL:      rd_addr = AW'(len_q - CW'(1));
      RD_ZERO:      rd_addr = '0;
      default:      rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_limit_q <= 16'(GAP_RESET);
      count_q     <= '0;
      total_q     <= '0;
      sum_vld_q   <= 1'b0;
    end else begin
      if (cfg_take_i) begin
        gap_limit_q <= cfg_data_i;
      end
      if (cmd_i.in_take) begin
        count_q <= count_d;
        total_q <= total_d;
      end
      sum_vld_q <= cmd_i.sum_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_take) begin
      mem[pos[AW-1:0]] <= rx_byte_i;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[rd_addr];
      idx_q     <= rd_addr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_take && complete) begin
      len_q <= tot_new;
      sum_q <= '0;
    end else if (sum_vld_q) begin
      sum_q <= sum_q + rd_data_q;
    end
  end

  always_comb begin
    sts_o.len_err  = len_err;
    sts_o.complete = complete;
    sts_o.sum_end  = (CW'(idx_q) + CW'(3)) == len_q;
    sts_o.is_last  = (CW'(idx_q) + CW'(1)) == len_q;
    sts_o.sum_ok   = sum_q == rd_data_q;
  end

  assign frame_byte_o = emit_byte_i ? rd_data_q : 8'd0;

endmodule

// ===== design/lfpr_ctrl.sv =====
// lfpr_ctrl: sequencer for input, checksum pass, check and frame replay
// drives lfpr_dp through cmd_t and reads sts_t, uses lfpr_pkg
module lfpr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lfpr_pkg::status_e    status_o,
  output logic                 last_o,
  output logic                 emit_byte_o,
  output lfpr_pkg::cmd_t       cmd_o,
  input  lfpr_pkg::sts_t       sts_i
);
  import lfpr_pkg::*;

  state_e state_q, state_d;
  logic   out_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    status_o      = STAT_BYTE;
    last_o        = 1'b0;
    emit_byte_o   = 1'b0;
    cmd_o.in_take = 1'b0;
    cmd_o.rd_en   = 1'b0;
    cmd_o.rd_sel  = RD_NEXT;
    cmd_o.sum_rd  = 1'b0;
    out_take      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.in_take = in_valid_i;
        if (in_valid_i) begin
          if (sts_i.len_err) begin
            state_d = ST_LEN_ERR;
          end else if (sts_i.complete) begin
            // first checksum byte goes out with the closing item
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = RD_SUM_START;
            cmd_o.sum_rd = 1'b1;
            state_d      = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        cmd_o.rd_en = 1'b1;
        if (sts_i.sum_end) begin
          cmd_o.rd_sel = RD_TAIL;
          state_d      = ST_CHECK;
        end else begin
          cmd_o.rd_sel = RD_NEXT;
          cmd_o.sum_rd = 1'b1;
        end
      end
      ST_CHECK: begin
        if (sts_i.sum_ok) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_ZERO;
          state_d      = ST_REPLAY;
        end else begin
          state_d = ST_SUM_ERR;
        end
      end
      ST_REPLAY: begin
        out_valid_o = 1'b1;
        emit_byte_o = 1'b1;
        last_o      = sts_i.is_last;
        out_take    = out_ready_i;
        if (out_ready_i) begin
          if (sts_i.is_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = RD_NEXT;
          end
        end
      end
      ST_SUM_ERR: begin
        out_valid_o = 1'b1;
        status_o    = STAT_SUM_ERR;
        last_o      = 1'b1;
        out_take    = out_ready_i;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      ST_LEN_ERR: begin
        out_valid_o = 1'b1;
        status_o    = STAT_LEN_ERR;
        last_o      = 1'b1;
        out_take    = out_ready_i;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // input and output sides are never open together
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output open in the same cycle");

  // an oversized length leads straight to its error item
  a_len_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && sts_i.len_err) |=>
      (out_valid_o && status_o == STAT_LEN_ERR && last_o))
    else $error("length error item missing");

  // a completed frame starts the checksum pass
  a_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !sts_i.len_err && sts_i.complete) |=>
      (state_q == ST_SUM))
    else $error("checksum pass not started");

  // taking the final item of a run reopens the input
  a_reopen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_take && last_o) |=> in_ready_o)
    else $error("input not reopened after final item");

endmodule

// ===== design/length_framed_packet_receiver.sv =====
// length_framed_packet_receiver: top level, joins lfpr_ctrl and lfpr_dp
// a byte that does not close a frame is taken while idle; a length error item
// shows in the cycle after its byte; a closing byte gives its first result
// after a checksum pass over the store read port and a trailing byte check,
// then one frame byte per cycle while out_ready_i is high
// throughput: one byte per cycle between frames; no byte is taken during the
// checksum pass or while results are pending. reset: asynchronous, active low;
// counters clear, gap limit becomes 280 ms, the frame store is left as is
module length_framed_packet_receiver #(
  parameter int unsigned FRAME_CAP = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic [15:0] gap_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [7:0]  frame_byte_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);
  import lfpr_pkg::*;

  cmd_t    cmd;
  sts_t    sts;
  status_e status;
  logic    emit_byte;

  // the gap limit register can take a write in any cycle
  assign cfg_ready_o = 1'b1;
  assign status_o    = status;

  lfpr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status),
    .last_o      (last_o),
    .emit_byte_o (emit_byte),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  lfpr_dp #(
    .FRAME_CAP (FRAME_CAP)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_take_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .rx_byte_i    (rx_byte_i),
    .gap_ms_i     (gap_ms_i),
    .emit_byte_i  (emit_byte),
    .frame_byte_o (frame_byte_o)
  );

endmodule

// ===== verif/tb_length_framed_packet_receiver.sv =====
// tb_length_framed_packet_receiver: self-checking bench for the length framed packet receiver
// predicts every result from the accepted bytes and the gap limit, checks the outputs in order
// depends on lfpr_pkg and length_framed_packet_receiver
`timescale 1ns / 1ps

module tb_length_framed_packet_receiver;
  import lfpr_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 4;
  localparam int FRAME_CAP      = 64;
  localparam int MAX_IDLE       = 12;
  localparam int SETTLE_CYCLES  = 80;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_FIRST     = 30;
  localparam int HOLD_SECOND    = 200;
  localparam int TIMEOUT_CYCLES = 2000000;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic [15:0] gap_ms;
  } rx_item_t;

  typedef struct {
    status_e    status;
    logic [7:0] fbyte;
    logic       last;
  } frame_result_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i    = '0;
  logic [15:0] gap_ms_i     = '0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [1:0]  status_o;
  logic [7:0]  frame_byte_o;
  logic        last_o;
  logic        cfg_valid_i  = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i   = '0;

  // receiver state as the bench sees it
  logic [7:0]  rx_mem [FRAME_CAP];
  logic [6:0]  rx_count  = '0;
  logic [7:0]  rx_total  = '0;
  logic [15:0] gap_limit = GAP_RESET;

  rx_item_t      rx_pending[$];
  frame_result_t expected_results[$];

  bit in_gaps_on  = 1'b1;
  bit out_gaps_on = 1'b1;
  int in_wait     = 0;
  int out_wait    = 0;
  int hold_left   = 0;

  int items_queued   = 0;
  int items_taken    = 0;
  int results_seen   = 0;
  int mismatches     = 0;
  int frames_ok      = 0;
  int sum_errs       = 0;
  int len_errs       = 0;
  int limits_written = 0;

  length_framed_packet_receiver #(
    .FRAME_CAP(FRAME_CAP)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .gap_ms_i    (gap_ms_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .frame_byte_o(frame_byte_o),
    .last_o      (last_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  task automatic push_result(input status_e st, input logic [7:0] b, input logic lst);
    frame_result_t r;
    r.status = st;
    r.fbyte  = b;
    r.last   = lst;
    expected_results.push_back(r);
  endtask

  // advance the frame state by one accepted byte and queue what it produces
  task automatic track_rx_byte(input logic [7:0] b, input logic [15:0] g);
    logic [6:0] pos;
    logic [8:0] total;
    logic [7:0] sum;
    if (g > gap_limit) begin
      rx_count = '0;
      rx_total = '0;
    end
    pos = rx_count;
    rx_mem[pos[5:0]] = b;
    rx_count = pos + 7'd1;
    if (pos == LEN_POS) begin
      total = {1'b0, b} + 9'(HDR_EXTRA);
      if (total > FRAME_CAP) begin
        rx_count = '0;
        rx_total = '0;
        push_result(STAT_LEN_ERR, 8'h00, 1'b1);
        return;
      end
      rx_total = total[7:0];
    end
    if (rx_total == 0 || {1'b0, rx_count} < rx_total) return;
    sum = '0;
    for (int i = SUM_START; i + 3 <= int'(rx_total); i++) sum += rx_mem[6'(i)];
    if (sum == rx_mem[6'(rx_total - 8'd1)]) begin
      for (int i = 0; i < int'(rx_total); i++)
        push_result(STAT_BYTE, rx_mem[6'(i)], (i + 1 == int'(rx_total)));
    end else begin
      push_result(STAT_SUM_ERR, 8'h00, 1'b1);
    end
    rx_count = '0;
    rx_total = '0;
  endtask

  task automatic queue_rx(input logic [7:0] b, input logic [15:0] g);
    rx_item_t itm;
    itm.rx_byte = b;
    itm.gap_ms  = g;
    rx_pending.push_back(itm);
    items_queued++;
  endtask

  // gap that keeps the current frame going
  function automatic logic [15:0] inner_gap();
    int lim = gap_limit;
    if (lim == 0) return 16'd0;
    case ($urandom_range(0, 3))
      0:       return 16'd0;
      1:       return 16'(lim);
      default: return 16'($urandom_range(0, lim));
    endcase
  endfunction

  // gap that opens a new frame, unless no gap can
  function automatic logic [15:0] restart_gap();
    int lim = gap_limit;
    if (lim == 65535) return 16'($urandom_range(0, 65535));
    case ($urandom_range(0, 3))
      0:       return 16'(lim + 1);
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(lim + 1, 65535));
    endcase
  endfunction

  function automatic int pick_len();
    int r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 12);
    if (r < 95) return $urandom_range(13, 40);
    return $urandom_range(41, FRAME_CAP - HDR_EXTRA);
  endfunction

  // keep <= 0 or above the frame size sends the whole frame, else only the first keep bytes
  task automatic queue_frame(input int len, input bit good, input int keep);
    logic [7:0] fb [FRAME_CAP];
    logic [7:0] sum;
    int n;
    n = len + HDR_EXTRA;
    for (int i = 0; i < FRAME_CAP; i++) fb[i] = 8'($urandom_range(0, 255));
    fb[LEN_POS] = 8'(len);
    if (n <= FRAME_CAP) begin
      sum = '0;
      for (int i = SUM_START; i + 3 <= n; i++) sum += fb[i];
      // with length zero the checksum byte is the length byte itself
      if (len == 0) fb[SUM_START] = good ? 8'h00 : 8'($urandom_range(1, 255));
      else fb[n - 1] = good ? sum : sum ^ 8'($urandom_range(1, 255));
    end else begin
      n = LEN_POS + 1;
    end
    if (keep <= 0 || keep > n) keep = n;
    for (int i = 0; i < keep; i++) queue_rx(fb[i], (i == 0) ? restart_gap() : inner_gap());
  endtask

  task automatic queue_random(input int n_items, input bit clean);
    int start_cnt;
    int r;
    int len;
    start_cnt = items_queued;
    while (items_queued - start_cnt < n_items) begin
      r = $urandom_range(0, 99);
      if (clean && r >= 85) r = $urandom_range(0, 84);
      if (r < 55) begin
        queue_frame(pick_len(), 1'b1, 0);
      end else if (r < 70) begin
        queue_frame(pick_len(), 1'b0, 0);
      end else if (r < 85) begin
        case ($urandom_range(0, 3))
          0:       len = FRAME_CAP - HDR_EXTRA + 1;
          1:       len = 255;
          default: len = $urandom_range(FRAME_CAP - HDR_EXTRA + 1, 255);
        endcase
        queue_frame(len, 1'b1, 0);
      end else if (r < 93) begin
        len = pick_len();
        queue_frame(len, 1'b1, $urandom_range(1, len + HDR_EXTRA - 1));
      end else begin
        repeat ($urandom_range(1, 4))
          queue_rx(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
      end
    end
    // close on a whole frame so the next setting starts aligned
    queue_frame($urandom_range(0, 4), 1'b1, 0);
  endtask

  // wait for everything in flight to finish, then let the checksum pass run out
  task automatic settle();
    do @(negedge clk_i);
    while (rx_pending.size() != 0 || in_valid_i || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic run_phase(input logic [15:0] limit, input bit in_gaps, input bit out_gaps,
                           input bit clean, input int n_items);
    settle();
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= limit;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    gap_limit = limit;
    limits_written++;
    @(negedge clk_i);
    in_gaps_on  = in_gaps;
    out_gaps_on = out_gaps;
    queue_random(n_items, clean);
  endtask

  // input side: presents queued items, updates the prediction on each accepted item
  always @(posedge clk_i) begin : rx_drive
    logic nxt_valid;
    rx_item_t itm;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      nxt_valid = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        track_rx_byte(rx_byte_i, gap_ms_i);
        items_taken++;
        nxt_valid = 1'b0;
        in_wait = (in_gaps_on && $urandom_range(0, 1)) ? $urandom_range(1, MAX_IDLE) : 0;
      end
      if (!nxt_valid) begin
        if (in_wait > 0) begin
          in_wait--;
        end else if (rx_pending.size() > 0) begin
          itm = rx_pending.pop_front();
          rx_byte_i <= itm.rx_byte;
          gap_ms_i  <= itm.gap_ms;
          nxt_valid = 1'b1;
        end
      end
      in_valid_i <= nxt_valid;
    end
  end

  // output side: checks each accepted result and throttles ready
  always @(posedge clk_i) begin : result_check
    frame_result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected result: status %0d frame_byte %0h last %0d",
                 status_o, frame_byte_o, last_o);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            mismatches++;
          end
          if (frame_byte_o !== want.fbyte) begin
            $error("frame_byte: expected %0h, got %0h", want.fbyte, frame_byte_o);
            mismatches++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last_o);
            mismatches++;
          end
          case (want.status)
            STAT_BYTE:    if (want.last) frames_ok++;
            STAT_SUM_ERR: sum_errs++;
            default:      len_errs++;
          endcase
        end
        out_wait = (out_gaps_on && $urandom_range(0, 1)) ? $urandom_range(1, MAX_IDLE) : 0;
        // long hold-off lets the block fill up and stall its input
        if (results_seen == HOLD_FIRST || results_seen == HOLD_SECOND) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (out_wait > 0) begin
        out_wait--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [7:0] edge_frame [9];
    edge_frame = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'h00, 8'hFF, 8'h00};
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    limits_written = 1;

    // shortest good frame, gaps at zero and exactly at the limit
    for (int i = 0; i < 9; i++)
      queue_rx(edge_frame[i], (i == 0) ? 16'd0 : ((i % 2) ? gap_limit : 16'd0));
    // smallest length that no longer fits
    queue_frame(FRAME_CAP - HDR_EXTRA + 1, 1'b1, 0);
    // frame cut off by a long gap
    queue_rx(8'h5A, 16'hFFFF);
    queue_rx(8'hA5, inner_gap());
    queue_rx(8'h3C, inner_gap());
    queue_rx(8'hC3, inner_gap());
    // largest frame that fits
    queue_frame(FRAME_CAP - HDR_EXTRA, 1'b1, 0);
    queue_random(20, 1'b0);

    run_phase(16'd0, 1'b1, 1'b1, 1'b0, 40);
    run_phase(16'hFFFF, 1'b1, 1'b0, 1'b1, 40);
    run_phase(16'($urandom_range(1, 65534)), 1'b0, 1'b1, 1'b0, 40);
    run_phase(16'd1, 1'b1, 1'b1, 1'b0, 40);
    run_phase(16'(GAP_RESET), 1'b0, 1'b0, 1'b0, 40);
    settle();

    $display("%0d input items and %0d results checked over %0d gap limit settings",
             items_taken, results_seen, limits_written);
    $display("frames replayed %0d, checksum errors %0d, length errors %0d",
             frames_ok, sum_errs, len_errs);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("length_framed_packet_receiver verification clean");
    end else begin
      $display("length_framed_packet_receiver verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("length_framed_packet_receiver verification failed");
    $finish;
  end

endmodule

// ===== length_framed_packet_receiver.f =====
design/lfpr_pkg.sv
design/lfpr_dp.sv
design/lfpr_ctrl.sv
design/length_framed_packet_receiver.sv
verif/tb_length_framed_packet_receiver.sv
